// ----- rtl/mfep_pkg.sv -----
// shared types and constants of the midi file event parser
// no dependencies
`default_nettype none
package mfep_pkg;

    localparam int unsigned MaxEventsDefault = 4096;
    localparam int unsigned MaxTracksDefault = 32;
    localparam int unsigned QueueDepth       = 4;
    localparam int unsigned DivBits          = 42;

    localparam logic [1:0] KIND_EVENT  = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_MAGIC      = 4'd1;
    localparam logic [3:0] ERR_HDR_LEN    = 4'd2;
    localparam logic [3:0] ERR_TIMING     = 4'd3;
    localparam logic [3:0] ERR_TRK_HDR    = 4'd4;
    localparam logic [3:0] ERR_TRK_TRUNC  = 4'd5;
    localparam logic [3:0] ERR_DELTA      = 4'd6;
    localparam logic [3:0] ERR_RUNNING    = 4'd7;
    localparam logic [3:0] ERR_META       = 4'd8;
    localparam logic [3:0] ERR_SYSEX      = 4'd9;
    localparam logic [3:0] ERR_EVT_TRUNC  = 4'd10;
    localparam logic [3:0] ERR_EVT_LIMIT  = 4'd11;
    localparam logic [3:0] ERR_NO_NOTES   = 4'd12;

    localparam logic [1:0] CFG_FILE_LENGTH = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_RATE = 2'd1;

    localparam logic [23:0] DefaultTempo   = 24'd500000;
    localparam logic [17:0] DefaultRate    = 18'd44100;
    localparam logic [19:0] UsPerSecond    = 20'd1000000;
    localparam logic [7:0]  META_TEMPO     = 8'h51;
    localparam logic [7:0]  ST_META        = 8'hff;
    localparam logic [7:0]  ST_SYSEX       = 8'hf0;
    localparam logic [7:0]  ST_SYSEX_ESC   = 8'hf7;
    localparam logic [7:0]  TYPE_NOTE_OFF  = 8'h80;
    localparam logic [7:0]  TYPE_NOTE_ON   = 8'h90;
    localparam logic [7:0]  TYPE_CTRL      = 8'hb0;
    localparam logic [7:0]  TYPE_PROGRAM   = 8'hc0;
    localparam logic [7:0]  TYPE_PRESSURE  = 8'hd0;

    typedef enum logic [3:0] {
        PH_HEADER, PH_HDR_SKIP, PH_TRK_HDR, PH_DELTA, PH_STATUS, PH_META_TYPE,
        PH_META_LEN, PH_TEMPO, PH_SYSEX_LEN, PH_SKIP, PH_DATA1, PH_DATA2, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE, BK_MUL, BK_DIV, BK_LOAD
    } back_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] event_tick;
        logic [7:0]  status_byte;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [31:0] samples_per_tick;
        logic [3:0]  error_code;
        logic [31:0] longest_tick;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] tick;
        logic [7:0]  status;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic [3:0]  err;
        logic [31:0] longest;
        logic        last;
        logic        is_tempo;
        logic [23:0] tempo;
        logic [14:0] tpq;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic room2;
    } q_stat_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  fbc;
        logic [31:0] pos;
        logic [31:0] hlen;
        logic [15:0] texp;
        logic [15:0] tdone;
        logic [14:0] tpq;
        logic [31:0] tend;
        logic [31:0] tick;
        logic [7:0]  rs;
        logic [7:0]  cur;
        logic [31:0] qacc;
        logic [7:0]  meta;
        logic [31:0] skip;
        logic [23:0] tempo;
        logic [7:0]  held;
        logic        note_on;
        logic [31:0] maxtick;
    } pstate_t;

    function automatic logic [7:0] hdr_magic(input logic [1:0] i);
        case (i)
            2'd0: hdr_magic = 8'h4d;
            2'd1: hdr_magic = 8'h54;
            2'd2: hdr_magic = 8'h68;
            default: hdr_magic = 8'h64;
        endcase
    endfunction

    function automatic logic [7:0] trk_magic(input logic [1:0] i);
        case (i)
            2'd0: trk_magic = 8'h4d;
            2'd1: trk_magic = 8'h54;
            2'd2: trk_magic = 8'h72;
            default: trk_magic = 8'h6b;
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- rtl/midi_file_event_parser.sv -----
// top level of the midi file event parser: config registers, front, queue, back
// depends on mfep_pkg, mfep_front, mfep_queue, mfep_back
//
// usage
// - s_ channel: one file byte per word, first_byte set on the first byte of a file
// - m_ channel: result words (events, finish, error), last marks the final word
//   caused by one byte; one byte gives zero, one or two words
// - cfg channel: cfg_index 0 writes file_length, 1 writes sample_rate; always ready,
//   write only while the parser is idle
// - throughput: one byte per cycle while the queue has room for two words
// - path: non-tempo words pass through the queue and the output register; tempo words
//   also go through a multiply and a bit-serial divide of a 42-bit numerator
// - the divider sets the rate for tempo events; bytes keep flowing into the
//   four-word queue behind it until it fills
// - a stalled m_ready holds the output word; the queue fills and s_ready drops
// - reset clears the parser, empties the queue and sets sample_rate to 44100
// - after finish or error all bytes are swallowed until one has first_byte set
`default_nettype none
module midi_file_event_parser
    import mfep_pkg::*;
#(
    parameter int unsigned MAX_EVENTS = MaxEventsDefault,
    parameter int unsigned MAX_TRACKS = MaxTracksDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  in_word_t         s_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_word_t        m_word,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    // configuration registers
    logic [31:0] file_length_reg;
    logic [17:0] sample_rate_reg;

    // queue connections
    logic [1:0] push_n;
    q_entry_t   push0, push1, head;
    q_stat_t    qstat;
    logic       pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_length_reg <= '0;
            sample_rate_reg <= DefaultRate;
        end else if (cfg_valid) begin
            // writes beyond the register list are dropped
            if (cfg_index == {6'd0, CFG_FILE_LENGTH}) file_length_reg <= cfg_data;
            if (cfg_index == {6'd0, CFG_SAMPLE_RATE}) sample_rate_reg <= cfg_data[17:0];
        end
    end

    // front: byte parser
    mfep_front #(
        .MAX_EVENTS(MAX_EVENTS),
        .MAX_TRACKS(MAX_TRACKS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .file_length(file_length_reg),
        .qstat      (qstat),
        .push_n     (push_n),
        .push0      (push0),
        .push1      (push1)
    );

    // short queue decoupling parse and tempo divide
    mfep_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push_n (push_n),
        .push0  (push0),
        .push1  (push1),
        .pop    (pop),
        .head   (head),
        .stat   (qstat)
    );

    // back: tempo conversion and output register
    mfep_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .sample_rate(sample_rate_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word)
    );

    // output checks
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid right after reset");
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word.kind != 2'd3))
        else $error("bad result kind");
    a_event_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.kind == KIND_EVENT |-> m_word.error_code == ERR_NONE)
        else $error("event word carries an error code");
    a_tempo_spt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.kind == KIND_EVENT && m_word.status_byte == ST_META
        |-> m_word.samples_per_tick != 32'd0)
        else $error("tempo word with zero samples per tick");
endmodule
`default_nettype wire

// ----- rtl/mfep_queue.sv -----
// four-entry queue between parser front and result back, up to two pushes a cycle
// depends on mfep_pkg
`default_nettype none
module mfep_queue
    import mfep_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic [1:0] push_n,
    input  q_entry_t      push0,
    input  q_entry_t      push1,
    input  wire logic     pop,
    output q_entry_t      head,
    output q_stat_t       stat
);
    q_entry_t   mem_reg [QueueDepth];
    logic [1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;

    always_comb begin
        wp_next  = wp_reg + push_n;
        rp_next  = rp_reg + {1'b0, pop};
        cnt_next = cnt_reg + {1'b0, push_n} - {2'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wp_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wp_reg + 2'd1] <= push1;
        end
    end

    assign head       = mem_reg[rp_reg];
    assign stat.empty = (cnt_reg == 3'd0);
    assign stat.room2 = (cnt_reg <= 3'd2);
endmodule
`default_nettype wire

// ----- rtl/mfep_front.sv -----
// byte parser: walks header and track chunks, classifies events, pushes result rows
// depends on mfep_pkg
`default_nettype none
module mfep_front
    import mfep_pkg::*;
#(
    parameter int unsigned MAX_EVENTS = MaxEventsDefault,
    parameter int unsigned MAX_TRACKS = MaxTracksDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  in_word_t         s_word,
    input  wire logic [31:0] file_length,
    input  q_stat_t          qstat,
    output logic [1:0]       push_n,
    output q_entry_t         push0,
    output q_entry_t         push1
);
    localparam int unsigned EvW = $clog2(MAX_EVENTS + 1);

    pstate_t        st_reg, st_next, sc;
    logic [EvW-1:0] evc_reg, evc_next, evc_cur;
    logic           acc;

    logic        ev_req, ev_tempo_flag, end_req, trk_req, fail_req, fin_req;
    logic        data1_go, fin_go, at_end, ev_ok, tail;
    logic [7:0]  ev_st, ev_d1, ev_d2, fin_c, b, ty;
    logic [23:0] ev_tempo;
    logic [3:0]  fail_code, vcode;
    logic [15:0] div;
    logic [31:0] len;
    logic [32:0] wide;
    q_entry_t    ev_row, tail_row;

    assign s_ready = qstat.room2;
    assign acc     = s_valid && s_ready;
    assign b       = s_word.data_byte;

    always_comb begin
        sc      = s_word.first_byte ? pstate_t'('0) : st_reg;
        evc_cur = s_word.first_byte ? '0 : evc_reg;
        st_next = sc;
        evc_next = evc_cur;
        ev_req = 1'b0; ev_tempo_flag = 1'b0; ev_st = '0; ev_d1 = '0; ev_d2 = '0;
        ev_tempo = '0; end_req = 1'b0; trk_req = 1'b0; fail_req = 1'b0;
        fin_req = 1'b0; fail_code = ERR_NONE; data1_go = 1'b0; fin_go = 1'b0;
        fin_c = '0; div = '0; len = '0; wide = '0; vcode = ERR_META;
        ty = '0;
        if (sc.phase != PH_DONE) begin
            st_next.pos = sc.pos + 32'd1;
        end
        at_end = (st_next.pos >= sc.tend);
        case (sc.phase)
            PH_HEADER: begin
                if (sc.pos == 32'd0 && file_length < 32'd14) begin
                    fail_req = 1'b1; fail_code = ERR_MAGIC;
                end else if (sc.pos < 32'd4) begin
                    if (b != hdr_magic(sc.pos[1:0])) begin
                        fail_req = 1'b1; fail_code = ERR_MAGIC;
                    end
                end else if (sc.pos < 32'd8) begin
                    st_next.hlen = {sc.hlen[23:0], b};
                    wide = {1'b0, st_next.hlen} + 33'd8;
                    if (sc.pos == 32'd7 && (st_next.hlen < 32'd6
                            || wide > {1'b0, file_length})) begin
                        fail_req = 1'b1; fail_code = ERR_HDR_LEN;
                    end
                end else if (sc.pos == 32'd10 || sc.pos == 32'd11) begin
                    st_next.texp = {sc.texp[7:0], b};
                end else if (sc.pos == 32'd12) begin
                    st_next.held = b;
                end else if (sc.pos == 32'd13) begin
                    div = {sc.held, b};
                    if (sc.texp == 16'd0 || {1'b0, sc.texp} > 17'(MAX_TRACKS)
                            || div[15] || div == 16'd0) begin
                        fail_req = 1'b1; fail_code = ERR_TIMING;
                    end else begin
                        st_next.tpq  = div[14:0];
                        st_next.held = '0;
                        ev_req = 1'b1; ev_tempo_flag = 1'b1; ev_st = ST_META;
                        ev_tempo = DefaultTempo;
                        if (sc.hlen > 32'd6) begin
                            st_next.skip  = sc.hlen - 32'd6;
                            st_next.phase = PH_HDR_SKIP;
                        end else begin
                            trk_req = 1'b1;
                        end
                    end
                end
            end
            PH_HDR_SKIP: begin
                st_next.skip = sc.skip - 32'd1;
                if (st_next.skip == 32'd0) trk_req = 1'b1;
            end
            PH_TRK_HDR: begin
                if (sc.fbc < 3'd4) begin
                    if (b != trk_magic(sc.fbc[1:0])) begin
                        fail_req = 1'b1; fail_code = ERR_TRK_HDR;
                    end
                end else begin
                    st_next.qacc = {sc.qacc[23:0], b};
                end
                st_next.fbc = sc.fbc + 3'd1;
                if (!fail_req && sc.fbc == 3'd7) begin
                    len = st_next.qacc;
                    if (st_next.pos > file_length || len > file_length - st_next.pos) begin
                        fail_req = 1'b1; fail_code = ERR_TRK_TRUNC;
                    end else begin
                        st_next.tend = st_next.pos + len;
                        st_next.tick = '0;
                        st_next.rs   = '0;
                        end_req = 1'b1;
                    end
                end
            end
            PH_DELTA: begin
                st_next.qacc = {sc.qacc[24:0], b[6:0]};
                st_next.fbc  = sc.fbc + 3'd1;
                if (!b[7]) begin
                    st_next.tick = sc.tick + st_next.qacc;
                    if (st_next.tick > sc.maxtick) st_next.maxtick = st_next.tick;
                    if (at_end) begin
                        fail_req = 1'b1; fail_code = ERR_EVT_TRUNC;
                    end else begin
                        st_next.phase = PH_STATUS;
                    end
                end else if (st_next.fbc >= 3'd4 || at_end) begin
                    fail_req = 1'b1; fail_code = ERR_DELTA;
                end
            end
            PH_STATUS: begin
                if (b[7]) begin
                    st_next.cur = b;
                    if (b < ST_SYSEX) st_next.rs = b;
                    if (b == ST_META) begin
                        if (at_end) begin
                            fail_req = 1'b1; fail_code = ERR_META;
                        end else st_next.phase = PH_META_TYPE;
                    end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
                        if (at_end) begin
                            fail_req = 1'b1; fail_code = ERR_SYSEX;
                        end else begin
                            st_next.phase = PH_SYSEX_LEN;
                            st_next.qacc = '0; st_next.fbc = '0;
                        end
                    end else begin
                        if (at_end) begin
                            fail_req = 1'b1; fail_code = ERR_EVT_TRUNC;
                        end else st_next.phase = PH_DATA1;
                    end
                end else if (sc.rs == 8'd0) begin
                    fail_req = 1'b1; fail_code = ERR_RUNNING;
                end else begin
                    st_next.cur = sc.rs;
                    data1_go = 1'b1;
                end
            end
            PH_META_TYPE: begin
                st_next.meta  = b;
                st_next.phase = PH_META_LEN;
                st_next.qacc  = '0; st_next.fbc = '0;
            end
            PH_META_LEN, PH_SYSEX_LEN: begin
                vcode = (sc.phase == PH_META_LEN) ? ERR_META : ERR_SYSEX;
                st_next.qacc = {sc.qacc[24:0], b[6:0]};
                st_next.fbc  = sc.fbc + 3'd1;
                if (!b[7]) begin
                    len = st_next.qacc;
                    if (len > sc.tend - st_next.pos) begin
                        fail_req = 1'b1; fail_code = vcode;
                    end else if (sc.phase == PH_META_LEN && sc.meta == META_TEMPO
                            && len == 32'd3) begin
                        st_next.phase = PH_TEMPO;
                        st_next.fbc = '0; st_next.tempo = '0;
                    end else begin
                        st_next.skip = len;
                        if (len == 32'd0) end_req = 1'b1;
                        else st_next.phase = PH_SKIP;
                    end
                end else if (st_next.fbc >= 3'd4 || at_end) begin
                    fail_req = 1'b1; fail_code = vcode;
                end
            end
            PH_TEMPO: begin
                st_next.tempo = {sc.tempo[15:0], b};
                st_next.fbc   = sc.fbc + 3'd1;
                if (st_next.fbc >= 3'd3) begin
                    ev_req = 1'b1; ev_tempo_flag = 1'b1; ev_st = ST_META;
                    ev_tempo = st_next.tempo;
                    end_req = 1'b1;
                end
            end
            PH_SKIP: begin
                st_next.skip = sc.skip - 32'd1;
                if (st_next.skip == 32'd0) end_req = 1'b1;
            end
            PH_DATA1: data1_go = 1'b1;
            PH_DATA2: begin
                fin_go = 1'b1; fin_c = b;
            end
            PH_DONE: ;
            default: st_next.phase = PH_DONE;
        endcase

        // channel message data bytes
        ty = st_next.cur & 8'hf0;
        if (data1_go) begin
            st_next.held = b;
            if (ty == TYPE_PROGRAM || ty == TYPE_PRESSURE) begin
                fin_go = 1'b1; fin_c = '0;
            end else if (at_end) begin
                fail_req = 1'b1; fail_code = ERR_EVT_TRUNC;
            end else begin
                st_next.phase = PH_DATA2;
            end
        end
        if (fin_go) begin
            if (ty == TYPE_NOTE_ON && fin_c != 8'd0) st_next.note_on = 1'b1;
            if (ty == TYPE_NOTE_OFF || ty == TYPE_NOTE_ON || ty == TYPE_CTRL
                    || ty == TYPE_PROGRAM) begin
                ev_req = 1'b1; ev_st = st_next.cur; ev_d1 = st_next.held; ev_d2 = fin_c;
            end
            end_req = 1'b1;
        end

        // event limit
        ev_ok = 1'b0;
        if (ev_req) begin
            if (evc_cur >= EvW'(MAX_EVENTS)) begin
                fail_req = 1'b1; fail_code = ERR_EVT_LIMIT;
                end_req = 1'b0; trk_req = 1'b0;
            end else begin
                ev_ok = 1'b1;
                evc_next = evc_cur + 1'b1;
                if (st_next.tick > st_next.maxtick) st_next.maxtick = st_next.tick;
            end
        end
        ev_row = '{kind: KIND_EVENT, tick: st_next.tick, status: ev_st, d1: ev_d1,
                   d2: ev_d2, err: ERR_NONE, longest: st_next.maxtick, last: 1'b0,
                   is_tempo: ev_tempo_flag, tempo: ev_tempo, tpq: st_next.tpq};

        // end of event: next delta, next track or end of file
        if (end_req) begin
            if (st_next.pos >= st_next.tend) begin
                st_next.tdone = sc.tdone + 16'd1;
                if (st_next.tdone >= st_next.texp) begin
                    if (st_next.note_on) begin
                        fin_req = 1'b1;
                        st_next.phase = PH_DONE;
                    end else begin
                        fail_req = 1'b1; fail_code = ERR_NO_NOTES;
                    end
                end else begin
                    trk_req = 1'b1;
                end
            end else begin
                st_next.phase = PH_DELTA;
                st_next.qacc = '0; st_next.fbc = '0;
            end
        end
        if (trk_req) begin
            if ({1'b0, st_next.pos} + 33'd8 > {1'b0, file_length}) begin
                fail_req = 1'b1; fail_code = ERR_TRK_HDR;
            end else begin
                st_next.phase = PH_TRK_HDR;
                st_next.fbc = '0; st_next.qacc = '0;
            end
        end
        if (fail_req) st_next.phase = PH_DONE;

        tail_row = '{kind: (fail_req ? KIND_ERROR : KIND_FINISH), tick: '0,
                     status: '0, d1: '0, d2: '0,
                     err: (fail_req ? fail_code : ERR_NONE),
                     longest: st_next.maxtick, last: 1'b1, is_tempo: 1'b0,
                     tempo: '0, tpq: '0};
        tail = fail_req || fin_req;

        push0 = ev_ok ? ev_row : tail_row;
        push1 = tail_row;
        push0.last = !(ev_ok && tail);
        if (!acc) push_n = 2'd0;
        else push_n = {1'b0, ev_ok} + {1'b0, tail};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= pstate_t'('0);
            evc_reg <= '0;
        end else if (acc) begin
            st_reg  <= st_next;
            evc_reg <= evc_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/mfep_back.sv -----
// result stage: turns tempo rows into samples per tick, holds the output word
// depends on mfep_pkg
`default_nettype none
module mfep_back
    import mfep_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  q_entry_t         head,
    input  q_stat_t          qstat,
    output logic             pop,
    input  wire logic [17:0] sample_rate,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_word_t        m_word
);
    localparam int unsigned CntW = $clog2(DivBits + 1);

    back_state_t     bs_reg, bs_next;
    q_entry_t        ent_reg;
    logic [DivBits-1:0] num_reg;
    logic [34:0]     den_reg;
    logic [35:0]     rem_reg, rem_sh;
    logic [31:0]     quo_reg;
    logic [CntW-1:0] cnt_reg;
    logic            out_free, load_plain, load_tempo;
    logic            mv_reg;
    out_word_t       mw_reg;
    logic [31:0]     spt;

    assign out_free = !mv_reg || m_ready;

    // next state
    always_comb begin
        bs_next = bs_reg;
        case (bs_reg)
            BK_IDLE: if (!qstat.empty && out_free && head.is_tempo) bs_next = BK_MUL;
            BK_MUL:  bs_next = BK_DIV;
            BK_DIV:  if (cnt_reg == CntW'(1)) bs_next = BK_LOAD;
            BK_LOAD: if (out_free) bs_next = BK_IDLE;
            default: bs_next = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        pop        = 1'b0;
        load_plain = 1'b0;
        load_tempo = 1'b0;
        case (bs_reg)
            BK_IDLE: begin
                pop        = !qstat.empty && out_free;
                load_plain = pop && !head.is_tempo;
            end
            BK_LOAD: load_tempo = out_free;
            default: ;
        endcase
    end

    assign rem_sh = {rem_reg[34:0], num_reg[DivBits-1]};
    assign spt    = (den_reg == 35'd0 || quo_reg == 32'd0) ? 32'd1 : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) bs_reg <= BK_IDLE;
        else bs_reg <= bs_next;
    end

    always_ff @(posedge aclk) begin
        if (pop) ent_reg <= head;
        case (bs_reg)
            BK_MUL: begin
                num_reg <= DivBits'(ent_reg.tempo * sample_rate);
                den_reg <= 35'(ent_reg.tpq * UsPerSecond);
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= CntW'(DivBits);
            end
            BK_DIV: begin
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_reg <= rem_sh - {1'b0, den_reg};
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) mv_reg <= 1'b0;
        else if (load_plain || load_tempo) mv_reg <= 1'b1;
        else if (m_ready) mv_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (load_plain) begin
            mw_reg <= '{kind: head.kind, event_tick: head.tick, status_byte: head.status,
                        first_data: head.d1, second_data: head.d2,
                        samples_per_tick: '0, error_code: head.err,
                        longest_tick: head.longest, last: head.last};
        end else if (load_tempo) begin
            mw_reg <= '{kind: ent_reg.kind, event_tick: ent_reg.tick,
                        status_byte: ent_reg.status, first_data: ent_reg.d1,
                        second_data: ent_reg.d2, samples_per_tick: spt,
                        error_code: ent_reg.err, longest_tick: ent_reg.longest,
                        last: ent_reg.last};
        end
    end

    assign m_valid = mv_reg;
    assign m_word  = mw_reg;
endmodule
`default_nettype wire

// ----- tb/sv/tb_midi_file_event_parser.sv -----
// self-checking testbench of the midi file event parser: streams generated midi files
// byte by byte, predicts every result word and compares it field by field
// depends on mfep_pkg and the midi_file_event_parser rtl
`default_nettype none
module tb_midi_file_event_parser;
    import mfep_pkg::*;

    localparam int unsigned SettleCycles = 60;   // covers the tempo divide path
    localparam int unsigned ByteTarget   = 1200;
    localparam int unsigned LimitEvents  = 4100;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_word_t    s_word;
    logic        m_valid;
    logic        m_ready;
    out_word_t   m_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;

    midi_file_event_parser u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // shared bookkeeping
    out_word_t   pending_words[$];   // expected result words, oldest first
    out_word_t   byte_words[$];      // words caused by the byte being predicted
    int unsigned mismatch_count;
    int unsigned words_seen;
    bit          no_idle;            // stretch with no idling on either side

    // ------------------------------------------------------------------
    // parser predictor: own copy of config and parse state
    // ------------------------------------------------------------------
    logic [31:0] cfg_flen;
    logic [17:0] cfg_rate;

    phase_t      ps_phase;
    int unsigned ps_cnt;
    logic [31:0] ps_pos;
    logic [31:0] ps_hlen;
    logic [15:0] ps_texp;
    logic [15:0] ps_tdone;
    logic [14:0] ps_tpq;
    logic [31:0] ps_tend;
    logic [31:0] ps_tick;
    logic [7:0]  ps_rs;
    logic [7:0]  ps_cur;
    logic [31:0] ps_qacc;
    logic [7:0]  ps_meta;
    logic [31:0] ps_skip;
    logic [23:0] ps_tempo;
    logic [7:0]  ps_held;
    int unsigned ps_nevents;
    bit          ps_noteon;
    logic [31:0] ps_maxtick;

    logic [7:0] hdr_id [4] = '{8'h4d, 8'h54, 8'h68, 8'h64};
    logic [7:0] trk_id [4] = '{8'h4d, 8'h54, 8'h72, 8'h6b};

    function void pr_clear();
        ps_phase   = PH_HEADER;
        ps_cnt     = 0;
        ps_pos     = '0;
        ps_hlen    = '0;
        ps_texp    = '0;
        ps_tdone   = '0;
        ps_tpq     = '0;
        ps_tend    = '0;
        ps_tick    = '0;
        ps_rs      = '0;
        ps_cur     = '0;
        ps_qacc    = '0;
        ps_meta    = '0;
        ps_skip    = '0;
        ps_tempo   = '0;
        ps_held    = '0;
        ps_nevents = 0;
        ps_noteon  = 1'b0;
        ps_maxtick = '0;
    endfunction

    function void pr_put(logic [1:0] k, logic [31:0] t, logic [7:0] st, logic [7:0] a,
                         logic [7:0] b2, logic [31:0] spt, logic [3:0] e);
        out_word_t w;
        if (byte_words.size() >= 2) return;
        w.kind             = k;
        w.event_tick       = t;
        w.status_byte      = st;
        w.first_data       = a;
        w.second_data      = b2;
        w.samples_per_tick = spt;
        w.error_code       = e;
        w.longest_tick     = ps_maxtick;
        w.last             = 1'b0;
        byte_words.push_back(w);
    endfunction

    function void pr_fail(logic [3:0] code);
        pr_put(KIND_ERROR, '0, '0, '0, '0, '0, code);
        ps_phase = PH_DONE;
    endfunction

    function bit pr_add_event(logic [7:0] st, logic [7:0] a, logic [7:0] b2,
                              logic [31:0] spt);
        if (ps_nevents >= MaxEventsDefault) begin
            pr_fail(ERR_EVT_LIMIT);
            return 1'b0;
        end
        ps_nevents++;
        if (ps_tick > ps_maxtick) ps_maxtick = ps_tick;
        pr_put(KIND_EVENT, ps_tick, st, a, b2, spt, ERR_NONE);
        return 1'b1;
    endfunction

    function logic [31:0] pr_spt(logic [23:0] tempo);
        longint unsigned den;
        longint unsigned q;
        den = longint'(ps_tpq) * 64'd1000000;
        if (den == 0) return 32'd1;
        q = (longint'(tempo) * longint'(cfg_rate)) / den;
        return (q[31:0] == 0) ? 32'd1 : q[31:0];
    endfunction

    function void pr_enter_trk();
        if ({32'd0, ps_pos} + 64'd8 > {32'd0, cfg_flen}) begin
            pr_fail(ERR_TRK_HDR);
            return;
        end
        ps_phase = PH_TRK_HDR;
        ps_cnt   = 0;
        ps_qacc  = '0;
    endfunction

    function void pr_start_vlq(phase_t ph);
        ps_phase = ph;
        ps_qacc  = '0;
        ps_cnt   = 0;
    endfunction

    function void pr_end_event();
        if (ps_pos >= ps_tend) begin
            ps_tdone = ps_tdone + 16'd1;
            if (ps_tdone >= ps_texp) begin
                if (ps_noteon) begin
                    pr_put(KIND_FINISH, '0, '0, '0, '0, '0, ERR_NONE);
                    ps_phase = PH_DONE;
                end else begin
                    pr_fail(ERR_NO_NOTES);
                end
            end else begin
                pr_enter_trk();
            end
        end else begin
            pr_start_vlq(PH_DELTA);
        end
    endfunction

    // 1 complete, 0 more bytes, -1 failed
    function int pr_vlq(logic [7:0] b, logic [3:0] code);
        ps_qacc = {ps_qacc[24:0], b[6:0]};
        ps_cnt++;
        if (!b[7]) return 1;
        if (ps_cnt >= 4 || ps_pos >= ps_tend) begin
            pr_fail(code);
            return -1;
        end
        return 0;
    endfunction

    function void pr_begin_skip(logic [31:0] len);
        ps_skip = len;
        if (len == 0) pr_end_event();
        else ps_phase = PH_SKIP;
    endfunction

    function void pr_finish_channel(logic [7:0] c);
        logic [7:0] typ;
        typ = ps_cur & 8'hf0;
        if (typ == TYPE_NOTE_ON && c != 0) ps_noteon = 1'b1;
        if (typ == TYPE_NOTE_OFF || typ == TYPE_NOTE_ON || typ == TYPE_CTRL ||
            typ == TYPE_PROGRAM) begin
            if (!pr_add_event(ps_cur, ps_held, c, '0)) return;
        end
        pr_end_event();
    endfunction

    function void pr_take_data1(logic [7:0] b);
        logic [7:0] typ;
        typ = ps_cur & 8'hf0;
        ps_held = b;
        if (typ == TYPE_PROGRAM || typ == TYPE_PRESSURE) pr_finish_channel(8'd0);
        else if (ps_pos >= ps_tend) pr_fail(ERR_EVT_TRUNC);
        else ps_phase = PH_DATA2;
    endfunction

    function void pr_take_status(logic [7:0] b);
        bit at_end;
        at_end = (ps_pos >= ps_tend);
        ps_cur = b;
        if (b < 8'hf0) ps_rs = b;
        if (b == ST_META) begin
            if (at_end) pr_fail(ERR_META);
            else ps_phase = PH_META_TYPE;
        end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
            if (at_end) pr_fail(ERR_SYSEX);
            else pr_start_vlq(PH_SYSEX_LEN);
        end else begin
            if (at_end) pr_fail(ERR_EVT_TRUNC);
            else ps_phase = PH_DATA1;
        end
    endfunction

    function void pr_header(logic [31:0] p, logic [7:0] b);
        logic [15:0] div;
        if (p == 0 && cfg_flen < 14) begin
            pr_fail(ERR_MAGIC);
        end else if (p < 4) begin
            if (b != hdr_id[p]) pr_fail(ERR_MAGIC);
        end else if (p < 8) begin
            ps_hlen = {ps_hlen[23:0], b};
            if (p == 7 && (ps_hlen < 6 ||
                           {32'd0, ps_hlen} + 64'd8 > {32'd0, cfg_flen}))
                pr_fail(ERR_HDR_LEN);
        end else if (p == 10 || p == 11) begin
            ps_texp = {ps_texp[7:0], b};
        end else if (p == 12) begin
            ps_held = b;
        end else if (p == 13) begin
            div = {ps_held, b};
            if (ps_texp == 0 || ps_texp > MaxTracksDefault || div[15] || div == 0) begin
                pr_fail(ERR_TIMING);
                return;
            end
            ps_tpq  = div[14:0];
            ps_held = '0;
            if (!pr_add_event(ST_META, '0, '0, pr_spt(DefaultTempo))) return;
            if (ps_hlen > 6) begin
                ps_skip  = ps_hlen - 6;
                ps_phase = PH_HDR_SKIP;
            end else begin
                pr_enter_trk();
            end
        end
    endfunction

    function void pr_trk_header(logic [7:0] b);
        int unsigned c;
        logic [31:0] len;
        c = ps_cnt;
        if (c < 4) begin
            if (b != trk_id[c]) begin
                pr_fail(ERR_TRK_HDR);
                return;
            end
        end else begin
            ps_qacc = {ps_qacc[23:0], b};
        end
        ps_cnt = c + 1;
        if (c != 7) return;
        len = ps_qacc;
        if (ps_pos > cfg_flen || len > cfg_flen - ps_pos) begin
            pr_fail(ERR_TRK_TRUNC);
            return;
        end
        ps_tend = ps_pos + len;
        ps_tick = '0;
        ps_rs   = '0;
        pr_end_event();
    endfunction

    // fills byte_words with the words one accepted byte causes
    function void predict_byte(logic [7:0] b, bit first);
        logic [31:0] p;
        logic [31:0] len;
        logic [3:0]  code;
        int          r;
        byte_words.delete();
        if (first) pr_clear();
        if (ps_phase == PH_DONE) return;
        p = ps_pos;
        ps_pos = p + 1;
        case (ps_phase)
            PH_HEADER: pr_header(p, b);
            PH_HDR_SKIP: begin
                ps_skip--;
                if (ps_skip == 0) pr_enter_trk();
            end
            PH_TRK_HDR: pr_trk_header(b);
            PH_DELTA: begin
                if (pr_vlq(b, ERR_DELTA) == 1) begin
                    ps_tick = ps_tick + ps_qacc;
                    if (ps_tick > ps_maxtick) ps_maxtick = ps_tick;
                    if (ps_pos >= ps_tend) pr_fail(ERR_EVT_TRUNC);
                    else ps_phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (b[7]) begin
                    pr_take_status(b);
                end else if (ps_rs == 0) begin
                    pr_fail(ERR_RUNNING);
                end else begin
                    ps_cur = ps_rs;
                    pr_take_data1(b);
                end
            end
            PH_META_TYPE: begin
                ps_meta = b;
                pr_start_vlq(PH_META_LEN);
            end
            PH_META_LEN, PH_SYSEX_LEN: begin
                code = (ps_phase == PH_META_LEN) ? ERR_META : ERR_SYSEX;
                r = pr_vlq(b, code);
                if (r == 1) begin
                    len = ps_qacc;
                    if (len > ps_tend - ps_pos) begin
                        pr_fail(code);
                    end else if (ps_phase == PH_META_LEN && ps_meta == META_TEMPO &&
                                 len == 3) begin
                        ps_phase = PH_TEMPO;
                        ps_cnt   = 0;
                        ps_tempo = '0;
                    end else begin
                        pr_begin_skip(len);
                    end
                end
            end
            PH_TEMPO: begin
                ps_tempo = {ps_tempo[15:0], b};
                ps_cnt++;
                if (ps_cnt >= 3) begin
                    if (pr_add_event(ST_META, '0, '0, pr_spt(ps_tempo))) pr_end_event();
                end
            end
            PH_SKIP: begin
                ps_skip--;
                if (ps_skip == 0) pr_end_event();
            end
            PH_DATA1: pr_take_data1(b);
            PH_DATA2: pr_finish_channel(b);
            default:  ps_phase = PH_DONE;
        endcase
        if (byte_words.size() > 0) byte_words[byte_words.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // file generator
    // ------------------------------------------------------------------
    logic [7:0]  file_q[$];
    logic [7:0]  trk_q[$];
    logic [31:0] file_len_cfg;

    function void put32(logic [31:0] v);
        file_q.push_back(v[31:24]);
        file_q.push_back(v[23:16]);
        file_q.push_back(v[15:8]);
        file_q.push_back(v[7:0]);
    endfunction

    // variable-length quantity, at most four groups
    function void trk_vlq(logic [27:0] v);
        logic [6:0] grp [4];
        int n;
        n = 0;
        do begin
            grp[n] = v[6:0];
            v = v >> 7;
            n++;
        end while (v != 0 && n < 4);
        for (int i = n - 1; i >= 0; i--) trk_q.push_back({(i != 0), grp[i]});
    endfunction

    function logic [7:0] data_val();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 127));
    endfunction

    function void gen_track(bit noisy);
        logic [7:0]  prev;
        logic [7:0]  st;
        logic [7:0]  typ;
        logic [23:0] tempo;
        int          nev;
        int          r;
        int          len;
        prev = '0;
        nev  = $urandom_range(1, 10);
        trk_q.delete();
        for (int e = 0; e < nev; e++) begin
            r = $urandom_range(0, 19);
            if (r < 12)      trk_vlq(28'($urandom_range(0, 127)));
            else if (r < 17) trk_vlq(28'($urandom_range(128, 16383)));
            else if (r < 19) trk_vlq(28'($urandom));
            else if (noisy) begin
                // five-group delta
                repeat (5) trk_q.push_back(8'h81);
            end else trk_vlq(28'd0);
            r = $urandom_range(0, 19);
            if (r < 12 || prev == 0) begin
                case ($urandom_range(0, 8))
                    0: typ = TYPE_NOTE_OFF;
                    1: typ = 8'ha0;
                    2: typ = TYPE_CTRL;
                    3: typ = TYPE_PROGRAM;
                    4: typ = TYPE_PRESSURE;
                    5: typ = 8'he0;
                    default: typ = TYPE_NOTE_ON;
                endcase
                st = typ | 8'($urandom_range(0, 15));
                if (!(st == prev && $urandom_range(0, 1))) trk_q.push_back(st);
                prev = st;
                trk_q.push_back(data_val());
                if (typ != TYPE_PROGRAM && typ != TYPE_PRESSURE)
                    trk_q.push_back((typ == TYPE_NOTE_ON && $urandom_range(0, 5) != 0)
                                    ? 8'($urandom_range(1, 127)) : data_val());
            end else if (r < 14) begin
                case ($urandom_range(0, 3))
                    0: tempo = 24'd0;
                    1: tempo = 24'hffffff;
                    2: tempo = 24'($urandom);
                    default: tempo = 24'($urandom_range(300000, 1000000));
                endcase
                trk_q.push_back(ST_META);
                trk_q.push_back(META_TEMPO);
                trk_q.push_back(8'd3);
                trk_q.push_back(tempo[23:16]);
                trk_q.push_back(tempo[15:8]);
                trk_q.push_back(tempo[7:0]);
            end else if (r < 16) begin
                trk_q.push_back(ST_META);
                trk_q.push_back($urandom_range(0, 3) == 0 ? META_TEMPO
                                                          : 8'($urandom_range(0, 255)));
                len = $urandom_range(0, 4);
                trk_vlq(28'(len));
                repeat (len) trk_q.push_back(8'($urandom_range(0, 255)));
            end else if (r < 18) begin
                trk_q.push_back($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC);
                len = $urandom_range(0, 5);
                trk_vlq(28'(len));
                repeat (len) trk_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                // system common: two bytes follow, nothing emitted
                st = 8'($urandom_range(8'hf1, 8'hfe));
                if (st == ST_SYSEX_ESC) st = 8'hf1;
                trk_q.push_back(st);
                trk_q.push_back(8'($urandom_range(0, 255)));
                trk_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        // end of track meta
        trk_q.push_back(8'h00);
        trk_q.push_back(ST_META);
        trk_q.push_back(8'h2f);
        trk_q.push_back(8'h00);
    endfunction

    function void gen_header(int hlen, logic [15:0] ntr, logic [15:0] div);
        file_q.delete();
        file_q.push_back(8'h4d);
        file_q.push_back(8'h54);
        file_q.push_back(8'h68);
        file_q.push_back(8'h64);
        put32(32'(hlen));
        file_q.push_back(8'h00);
        file_q.push_back(8'($urandom_range(0, 2)));
        file_q.push_back(ntr[15:8]);
        file_q.push_back(ntr[7:0]);
        file_q.push_back(div[15:8]);
        file_q.push_back(div[7:0]);
        for (int i = 6; i < hlen; i++) file_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function void gen_file();
        bit          noisy;
        int          hlen;
        int          ntr;
        int          tlen;
        logic [15:0] div;
        noisy = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 19))
            0: ntr = 0;
            1: ntr = MaxTracksDefault + 1;
            default: ntr = $urandom_range(1, 3);
        endcase
        case ($urandom_range(0, 19))
            0: div = 16'd0;
            1: div = 16'h7fff;
            2: div = 16'd1;
            3: div = 16'h8000 | 16'($urandom_range(0, 16'h7fff));
            default: div = 16'($urandom_range(24, 960));
        endcase
        hlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : 6;
        if (noisy && $urandom_range(0, 5) == 0) hlen = $urandom_range(0, 5);
        gen_header(hlen, 16'(ntr), div);
        for (int t = 0; t < ((ntr > 3) ? 2 : ntr); t++) begin
            gen_track(noisy);
            tlen = trk_q.size();
            if (noisy && $urandom_range(0, 1)) tlen = tlen + $urandom_range(0, 6) - 3;
            file_q.push_back(8'h4d);
            file_q.push_back(8'h54);
            file_q.push_back(8'h72);
            file_q.push_back(8'h6b);
            put32(32'(tlen));
            foreach (trk_q[i]) file_q.push_back(trk_q[i]);
        end
        file_len_cfg = file_q.size();
        case ($urandom_range(0, 19))
            0: file_len_cfg = $urandom_range(0, 13);
            1: file_len_cfg = file_q.size() - $urandom_range(1, 4);
            2: file_len_cfg = file_q.size() + $urandom_range(1, 100);
            3: file_len_cfg = 32'hffffffff;
            default: ;
        endcase
        if (noisy && $urandom_range(0, 1))
            file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom_range(0, 255));
        // trailing bytes past the last track are swallowed
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5)) file_q.push_back(8'($urandom_range(0, 255)));
        if (noisy && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 8)) if (file_q.size() > 1) void'(file_q.pop_back());
    endfunction

    // one track of program changes under running status, past the event limit
    function void gen_limit_file();
        gen_header(6, 16'd1, 16'd96);
        trk_q.delete();
        trk_q.push_back(8'h00);
        trk_q.push_back(TYPE_PROGRAM);
        trk_q.push_back(8'h05);
        repeat (LimitEvents) begin
            trk_q.push_back(8'h00);
            trk_q.push_back(8'($urandom_range(0, 127)));
        end
        file_q.push_back(8'h4d);
        file_q.push_back(8'h54);
        file_q.push_back(8'h72);
        file_q.push_back(8'h6b);
        put32(32'(trk_q.size()));
        foreach (trk_q[i]) file_q.push_back(trk_q[i]);
        file_len_cfg = file_q.size();
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FILE_LENGTH) cfg_flen = val;
        else if (idx == CFG_SAMPLE_RATE) cfg_rate = val[17:0];
    endtask

    // offers one byte word; typed_err overrides the prediction when nonzero
    task automatic send_byte(logic [7:0] b, bit first, logic [3:0] typed_err);
        int unsigned gap;
        out_word_t   w;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= '{data_byte: b, first_byte: first};
        do @(posedge aclk); while (!s_ready);
        predict_byte(b, first);
        if (typed_err != ERR_NONE) begin
            // read straight off the spec: an early error word after a clear
            w = '0;
            w.kind       = KIND_ERROR;
            w.error_code = typed_err;
            w.last       = 1'b1;
            pending_words.push_back(w);
        end else begin
            foreach (byte_words[i]) pending_words.push_back(byte_words[i]);
        end
    endtask

    task automatic stream_file(bit set_rate);
        wait_idle();
        write_reg(CFG_FILE_LENGTH, file_len_cfg);
        if (set_rate) begin
            case ($urandom_range(0, 3))
                0: write_reg(CFG_SAMPLE_RATE, 32'd1);
                1: write_reg(CFG_SAMPLE_RATE, 32'd192000);
                2: write_reg(CFG_SAMPLE_RATE, 32'(DefaultRate));
                default: write_reg(CFG_SAMPLE_RATE, $urandom_range(1, 192000));
            endcase
        end
        no_idle = ($urandom_range(0, 4) == 0);
        foreach (file_q[i]) send_byte(file_q[i], (i == 0), ERR_NONE);
    endtask

    // ------------------------------------------------------------------
    // directed rows: register writes and bytes, some with typed expectations
    // ------------------------------------------------------------------
    typedef struct {
        bit          is_cfg;
        logic [31:0] val;
        bit          first;
        logic [3:0]  typed_err;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function void add_row(bit is_cfg, logic [31:0] val, bit first, logic [3:0] err);
        dir_rows.push_back('{is_cfg: is_cfg, val: val, first: first, typed_err: err});
    endfunction

    function void add_bytes(logic [7:0] bytes[$]);
        foreach (bytes[i]) add_row(1'b0, 32'(bytes[i]), (i == 0), ERR_NONE);
    endfunction

    // ------------------------------------------------------------------
    // result word checker
    // ------------------------------------------------------------------
    task automatic check_word(out_word_t got);
        out_word_t want;
        if (pending_words.size() == 0) begin
            $error("unexpected result word %p", got);
            mismatch_count++;
            return;
        end
        want = pending_words.pop_front();
        if (got.kind != want.kind) begin
            $error("kind: expected %0d actual %0d", want.kind, got.kind);
            mismatch_count++;
        end
        if (got.event_tick != want.event_tick) begin
            $error("event_tick: expected %0d actual %0d", want.event_tick, got.event_tick);
            mismatch_count++;
        end
        if (got.status_byte != want.status_byte) begin
            $error("status_byte: expected %h actual %h", want.status_byte, got.status_byte);
            mismatch_count++;
        end
        if (got.first_data != want.first_data) begin
            $error("first_data: expected %h actual %h", want.first_data, got.first_data);
            mismatch_count++;
        end
        if (got.second_data != want.second_data) begin
            $error("second_data: expected %h actual %h", want.second_data, got.second_data);
            mismatch_count++;
        end
        if (got.samples_per_tick != want.samples_per_tick) begin
            $error("samples_per_tick: expected %0d actual %0d",
                   want.samples_per_tick, got.samples_per_tick);
            mismatch_count++;
        end
        if (got.error_code != want.error_code) begin
            $error("error_code: expected %0d actual %0d", want.error_code, got.error_code);
            mismatch_count++;
        end
        if (got.longest_tick != want.longest_tick) begin
            $error("longest_tick: expected %0d actual %0d",
                   want.longest_tick, got.longest_tick);
            mismatch_count++;
        end
        if (got.last != want.last) begin
            $error("last: expected %0d actual %0d", want.last, got.last);
            mismatch_count++;
        end
    endtask

    // receiver: random stalls, one long hold-off so the queue fills and s_ready drops
    initial begin
        int unsigned stall;
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            if (words_seen == 40) stall = 400;
            else stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            words_seen++;
            check_word(m_word);
        end
    end

    // run limit
    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned sent;
        int unsigned nfiles;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_word    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        mismatch_count = 0;
        words_seen     = 0;
        no_idle        = 1'b0;
        cfg_flen       = '0;
        cfg_rate       = DefaultRate;
        pr_clear();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short file: error on its first byte, then the rest is swallowed
        add_row(1'b1, 32'd10, 1'b0, ERR_NONE);
        add_row(1'b0, 32'h4d, 1'b1, ERR_MAGIC);
        add_row(1'b0, 32'h54, 1'b0, ERR_NONE);
        // bad magic on a full-length file
        add_row(1'b1, 32'd26, 1'b0, ERR_NONE);
        add_row(1'b0, 32'h00, 1'b1, ERR_MAGIC);
        // minimal valid file: default tempo, one note on, finish
        add_bytes('{8'h4d, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h06,
                    8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h60,
                    8'h4d, 8'h54, 8'h72, 8'h6b, 8'h00, 8'h00, 8'h00, 8'h04,
                    8'h00, 8'h90, 8'h3c, 8'h40});
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                wait_idle();
                write_reg(CFG_FILE_LENGTH, dir_rows[i].val);
            end else begin
                send_byte(dir_rows[i].val[7:0], dir_rows[i].first, dir_rows[i].typed_err);
            end
        end

        // random files, one of them long enough to hit the event limit
        sent   = 0;
        nfiles = 0;
        while (sent < ByteTarget) begin
            if (nfiles == 5) gen_limit_file();
            else gen_file();
            stream_file(nfiles == 0 || $urandom_range(0, 3) == 0);
            sent += file_q.size();
            nfiles++;
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
